// ===== src/htp_pkg.sv =====
// ----------------------------------------------------------------------------
// htp_pkg: shared types and constants for hit_to_polar_about_vertex
// Word layouts of both channels, register indexes, datapath widths and the
// arctangent table of the CORDIC stages.
// ----------------------------------------------------------------------------
package htp_pkg;

	// Register port geometry.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 19;

	// Register indexes.
	localparam logic [CFG_IW-1:0] REG_WIRE_PITCH = 3'd0;
	localparam logic [CFG_IW-1:0] REG_TIME_SCALE = 3'd1;
	localparam logic [CFG_IW-1:0] REG_VTX_WIRE0  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_VTX_WIRE1  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_VTX_WIRE2  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_VTX_TIME0  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_VTX_TIME1  = 3'd6;
	localparam logic [CFG_IW-1:0] REG_VTX_TIME2  = 3'd7;

	// Reset values of the scale registers.
	localparam logic [15:0] WIRE_PITCH_RST = 16'd19661;
	localparam logic [15:0] TIME_SCALE_RST = 16'd3604;

	// Datapath widths: CORDIC x/y, angle accumulator, square root remainder.
	localparam int XW = 43;
	localparam int ZW = 26;
	localparam int RW = 41;

	// Number of result bits of the square root.
	localparam int SQRT_STEPS = 20;

	// Saturation limits and angle constants.
	localparam logic [17:0] POS_MAX    = 18'h3FFFF;
	localparam logic [20:0] RAD_MAX    = 21'd524287;
	localparam logic [15:0] ANGLE_FULL = 16'd46080;
	localparam logic [15:0] ANGLE_HALF = 16'd23040;
	localparam logic signed [ZW-1:0] Z_QUARTER = 26'sd5898240;
	// Half turn in 2^-16 degree plus the rounding half of a 1/128 degree.
	localparam logic signed [ZW:0] Z_OFFSET = 27'sd11796736;

	// Input word.
	typedef struct packed {
		logic [1:0]  plane;
		logic [12:0] wire_req;
		logic [16:0] peak_time;
		logic [19:0] charge;
		logic [19:0] hit_index;
	} hit_word_t;

	// Result word.
	typedef struct packed {
		logic [18:0] radius;
		logic [15:0] angle;
		logic [17:0] wire_position;
		logic [17:0] time_position;
		logic [19:0] charge_out;
		logic [1:0]  plane_out;
		logic [19:0] hit_index_out;
	} polar_word_t;

	// Contents of one iteration stage.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [RW-1:0]        rem;
		logic [RW-1:0]        res;
		logic [17:0]          wpos;
		logic [17:0]          tpos;
		logic [19:0]          charge;
		logic [1:0]           plane;
		logic [19:0]          hit_index;
		logic                 at_vertex;
		logic                 neg_axis;
	} iter_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic [21:0] atan_lut(input int i);
		logic [21:0] v;
		case (i)
			0:       v = 22'd2949120;
			1:       v = 22'd1740967;
			2:       v = 22'd919879;
			3:       v = 22'd466945;
			4:       v = 22'd234379;
			5:       v = 22'd117304;
			6:       v = 22'd58666;
			7:       v = 22'd29335;
			8:       v = 22'd14668;
			9:       v = 22'd7334;
			10:      v = 22'd3667;
			11:      v = 22'd1833;
			12:      v = 22'd917;
			13:      v = 22'd458;
			14:      v = 22'd229;
			15:      v = 22'd115;
			16:      v = 22'd57;
			17:      v = 22'd29;
			18:      v = 22'd14;
			19:      v = 22'd7;
			20:      v = 22'd4;
			21:      v = 22'd2;
			22:      v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/hit_to_polar_about_vertex.sv =====
// ----------------------------------------------------------------------------
// hit_to_polar_about_vertex: polar position of a hit about its plane vertex
// Scales wire and drift time to positions, subtracts the plane's vertex and
// returns radius (square root) and angle (CORDIC) with the hit data.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+------------------------
//  hit      | in        | hit_valid / hit_stall     | htp_pkg::hit_word_t
//  polar    | out       | polar_valid / polar_stall | htp_pkg::polar_word_t
//  cfg      | in        | cfg_we                    | cfg_index, cfg_data
//
// One word enters per cycle unless the output stalls. There are four front
// stages (multiply, vertex subtract, square and prerotate, sum of squares),
// one stage per CORDIC iteration, which also carries the square root digits,
// and the output register. Reset clears all valid bits and loads the default
// scale registers. While the output word is stalled the whole pipeline holds.
// ----------------------------------------------------------------------------
module hit_to_polar_about_vertex #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hit_valid,
	output logic                          hit_stall,
	input  htp_pkg::hit_word_t            hit_word,
	output logic                          polar_valid,
	input  logic                          polar_stall,
	output htp_pkg::polar_word_t          polar_word,
	input  logic                          cfg_we,
	input  logic [htp_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [htp_pkg::CFG_DW-1:0]    cfg_data
);

	localparam int SQRT_PER = (htp_pkg::SQRT_STEPS + CORDIC_STAGES - 1) / CORDIC_STAGES;

	// Configuration registers.
	logic [15:0]        wire_pitch_q;
	logic [15:0]        time_scale_q;
	logic signed [18:0] vtx_wire_q [3];
	logic signed [18:0] vtx_time_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_pitch_q <= htp_pkg::WIRE_PITCH_RST;
			time_scale_q <= htp_pkg::TIME_SCALE_RST;
			for (int p = 0; p < 3; p++) begin
				vtx_wire_q[p] <= '0;
				vtx_time_q[p] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				htp_pkg::REG_WIRE_PITCH: wire_pitch_q <= cfg_data[15:0];
				htp_pkg::REG_TIME_SCALE: time_scale_q <= cfg_data[15:0];
				htp_pkg::REG_VTX_WIRE0:  vtx_wire_q[0] <= cfg_data;
				htp_pkg::REG_VTX_WIRE1:  vtx_wire_q[1] <= cfg_data;
				htp_pkg::REG_VTX_WIRE2:  vtx_wire_q[2] <= cfg_data;
				htp_pkg::REG_VTX_TIME0:  vtx_time_q[0] <= cfg_data;
				htp_pkg::REG_VTX_TIME1:  vtx_time_q[1] <= cfg_data;
				htp_pkg::REG_VTX_TIME2:  vtx_time_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves as a whole whenever the output register can take a word.
	logic adv;
	assign adv = !polar_valid || !polar_stall;
	assign hit_stall = !adv;

	// Stage 1: scale products and vertex of the hit's plane.
	logic               valid_s1;
	htp_pkg::hit_word_t hit_s1;
	logic [28:0]        wprod_s1;
	logic [32:0]        tprod_s1;
	logic signed [18:0] vw_s1;
	logic signed [18:0] vt_s1;
	logic signed [18:0] vw_c;
	logic signed [18:0] vt_c;

	always_comb begin
		case (hit_word.plane)
			2'd0:    begin vw_c = vtx_wire_q[0]; vt_c = vtx_time_q[0]; end
			2'd1:    begin vw_c = vtx_wire_q[1]; vt_c = vtx_time_q[1]; end
			2'd2:    begin vw_c = vtx_wire_q[2]; vt_c = vtx_time_q[2]; end
			default: begin vw_c = '0; vt_c = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= hit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1   <= hit_word;
			wprod_s1 <= 29'(hit_word.wire_req) * 29'(wire_pitch_q);
			tprod_s1 <= 33'(hit_word.peak_time) * 33'(time_scale_q);
			vw_s1    <= vw_c;
			vt_s1    <= vt_c;
		end
	end

	// Stage 2: round and saturate positions, offsets from the vertex.
	logic               valid_s2;
	htp_pkg::hit_word_t hit_s2;
	logic [17:0]        wpos_s2;
	logic [17:0]        tpos_s2;
	logic signed [19:0] dx_s2;
	logic signed [19:0] dt_s2;
	logic [29:0]        wsum_c;
	logic [33:0]        tsum_c;
	logic [17:0]        wpos_c;
	logic [17:0]        tpos_c;

	always_comb begin
		wsum_c = {1'b0, wprod_s1} + 30'd512;
		tsum_c = {1'b0, tprod_s1} + 34'd8192;
		wpos_c = (wsum_c[29:28] != 2'b00) ? htp_pkg::POS_MAX : wsum_c[27:10];
		tpos_c = (tsum_c[33:32] != 2'b00) ? htp_pkg::POS_MAX : tsum_c[31:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2  <= hit_s1;
			wpos_s2 <= wpos_c;
			tpos_s2 <= tpos_c;
			dx_s2   <= $signed({2'b00, wpos_c}) - $signed({vw_s1[18], vw_s1});
			dt_s2   <= $signed({2'b00, tpos_c}) - $signed({vt_s1[18], vt_s1});
		end
	end

	// Stage 3: squares, special cases and CORDIC prerotation into the right half.
	logic               valid_s3;
	htp_pkg::hit_word_t hit_s3;
	logic [17:0]        wpos_s3;
	logic [17:0]        tpos_s3;
	logic [39:0]        sqx_s3;
	logic [39:0]        sqy_s3;
	logic signed [htp_pkg::XW-1:0] x_s3;
	logic signed [htp_pkg::XW-1:0] y_s3;
	logic signed [htp_pkg::ZW-1:0] z_s3;
	logic               at_vertex_s3;
	logic               neg_axis_s3;
	logic signed [39:0] sqx_c;
	logic signed [39:0] sqy_c;
	logic signed [htp_pkg::XW-1:0] xa_c;
	logic signed [htp_pkg::XW-1:0] ya_c;
	logic signed [htp_pkg::XW-1:0] x0_c;
	logic signed [htp_pkg::XW-1:0] y0_c;
	logic signed [htp_pkg::ZW-1:0] z0_c;

	always_comb begin
		sqx_c = dx_s2 * dx_s2;
		sqy_c = dt_s2 * dt_s2;
		xa_c  = {{3{dx_s2[19]}}, dx_s2, 20'b0};
		ya_c  = {{3{dt_s2[19]}}, dt_s2, 20'b0};
		x0_c  = xa_c;
		y0_c  = ya_c;
		z0_c  = '0;
		if (dx_s2[19]) begin
			if (!dt_s2[19]) begin
				x0_c = ya_c;
				y0_c = -xa_c;
				z0_c = htp_pkg::Z_QUARTER;
			end else begin
				x0_c = -ya_c;
				y0_c = xa_c;
				z0_c = -htp_pkg::Z_QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s3       <= hit_s2;
			wpos_s3      <= wpos_s2;
			tpos_s3      <= tpos_s2;
			sqx_s3       <= sqx_c;
			sqy_s3       <= sqy_c;
			x_s3         <= x0_c;
			y_s3         <= y0_c;
			z_s3         <= z0_c;
			at_vertex_s3 <= (dx_s2 == '0) && (dt_s2 == '0);
			neg_axis_s3  <= (dt_s2 == '0) && dx_s2[19];
		end
	end

	// Stage 4: sum of squares seeds the square root.
	logic           valid_s4;
	htp_pkg::iter_t it_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s4.x         <= x_s3;
			it_s4.y         <= y_s3;
			it_s4.z         <= z_s3;
			it_s4.rem       <= htp_pkg::RW'(sqx_s3) + htp_pkg::RW'(sqy_s3);
			it_s4.res       <= '0;
			it_s4.wpos      <= wpos_s3;
			it_s4.tpos      <= tpos_s3;
			it_s4.charge    <= hit_s3.charge;
			it_s4.plane     <= hit_s3.plane;
			it_s4.hit_index <= hit_s3.hit_index;
			it_s4.at_vertex <= at_vertex_s3;
			it_s4.neg_axis  <= neg_axis_s3;
		end
	end

	// Iteration stages: one CORDIC rotation each, square root digits alongside.
	logic           it_valid [CORDIC_STAGES+1];
	htp_pkg::iter_t it_data  [CORDIC_STAGES+1];

	assign it_valid[0] = valid_s4;
	assign it_data[0]  = it_s4;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
		htp_iter_stage #(
			.ITER     (g),
			.SQRT_PER (SQRT_PER)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (it_valid[g]),
			.d        (it_data[g]),
			.valid_q  (it_valid[g+1]),
			.state_q  (it_data[g+1])
		);
	end

	// Output stage: round the radius, wrap the angle, apply special cases.
	htp_pkg::iter_t fin;
	logic [20:0]    rad_c;
	logic [18:0]    radius_c;
	logic signed [htp_pkg::ZW:0] zsum_c;
	logic signed [17:0] a9_c;
	logic signed [17:0] aw_c;
	logic [15:0]    angle_c;

	assign fin = it_data[CORDIC_STAGES];

	always_comb begin
		rad_c    = {1'b0, fin.res[19:0]} + 21'(fin.rem > fin.res);
		radius_c = (rad_c > htp_pkg::RAD_MAX) ? htp_pkg::RAD_MAX[18:0] : rad_c[18:0];
		zsum_c   = $signed({fin.z[htp_pkg::ZW-1], fin.z}) + htp_pkg::Z_OFFSET;
		a9_c     = 18'(zsum_c >>> 9);
		aw_c     = a9_c;
		if (a9_c < 0) begin
			aw_c = a9_c + $signed({2'b00, htp_pkg::ANGLE_FULL});
		end else if (a9_c >= $signed({2'b00, htp_pkg::ANGLE_FULL})) begin
			aw_c = a9_c - $signed({2'b00, htp_pkg::ANGLE_FULL});
		end
		if (fin.at_vertex) begin
			angle_c = htp_pkg::ANGLE_HALF;
		end else if (fin.neg_axis) begin
			angle_c = '0;
		end else begin
			angle_c = aw_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_valid <= 1'b0;
		end else if (adv) begin
			polar_valid <= it_valid[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			polar_word.radius        <= radius_c;
			polar_word.angle         <= angle_c;
			polar_word.wire_position <= fin.wpos;
			polar_word.time_position <= fin.tpos;
			polar_word.charge_out    <= fin.charge;
			polar_word.plane_out     <= fin.plane;
			polar_word.hit_index_out <= fin.hit_index;
		end
	end

endmodule

// ===== src/htp_iter_stage.sv =====
// ----------------------------------------------------------------------------
// htp_iter_stage: one CORDIC rotation plus square root steps
// Performs vectoring iteration ITER on (x, y, z) and up to SQRT_PER digit steps of
// the square root on (rem, res), then registers the result.
// ----------------------------------------------------------------------------
module htp_iter_stage #(
	parameter int ITER     = 0,
	parameter int SQRT_PER = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             valid_in,
	input  htp_pkg::iter_t   d,
	output logic             valid_q,
	output htp_pkg::iter_t   state_q
);

	localparam logic signed [htp_pkg::ZW-1:0] ATAN_I =
		htp_pkg::ZW'(htp_pkg::atan_lut(ITER));

	htp_pkg::iter_t nxt;

	// One rotation toward the x axis and the square root digit steps.
	always_comb begin
		logic signed [htp_pkg::XW-1:0] xs;
		logic signed [htp_pkg::XW-1:0] ys;
		logic [htp_pkg::RW-1:0] rem_v;
		logic [htp_pkg::RW-1:0] res_v;
		logic [htp_pkg::RW-1:0] bitv;
		logic [htp_pkg::RW-1:0] trial;
		int k;
		nxt = d;
		bitv = '0;
		trial = '0;
		k = 0;
		xs = d.x >>> ITER;
		ys = d.y >>> ITER;
		if (!d.y[htp_pkg::XW-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ATAN_I;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ATAN_I;
		end
		rem_v = d.rem;
		res_v = d.res;
		for (int m = 0; m < SQRT_PER; m++) begin
			k = ITER * SQRT_PER + m;
			if (k < htp_pkg::SQRT_STEPS) begin
				bitv = htp_pkg::RW'(1) << (2 * (htp_pkg::SQRT_STEPS - 1 - k));
				trial = res_v + bitv;
				if (rem_v >= trial) begin
					rem_v = rem_v - trial;
					res_v = (res_v >> 1) + bitv;
				end else begin
					res_v = res_v >> 1;
				end
			end
		end
		nxt.rem = rem_v;
		nxt.res = res_v;
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_q <= nxt;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for hit_to_polar_about_vertex
// Hits are queued by a sequencing block and sent by a clocked driver in bursts.
// Each accepted hit is predicted into a polar word from a local copy of the
// registers. A monitor compares every output word, field by field, with the
// oldest prediction while the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CORDIC_N = 16;
	localparam int LATENCY = CORDIC_N + 5;
	localparam int CYCLE_LIMIT = 500000;
	localparam longint DEG_Q16 = 65536;

	// Arctangent of 2^-i, in units of 2^-16 degree.
	localparam longint ATAN_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 hit_valid = 1'b0;
	logic                 hit_stall;
	htp_pkg::hit_word_t   hit_word = '0;
	logic                 polar_valid;
	logic                 polar_stall = 1'b0;
	htp_pkg::polar_word_t polar_word;
	logic                 cfg_we = 1'b0;
	logic [htp_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [htp_pkg::CFG_DW-1:0] cfg_data = '0;

	// Local copy of the registers, as the block should hold them.
	logic [15:0]        pitch_q = htp_pkg::WIRE_PITCH_RST;
	logic [15:0]        scale_q = htp_pkg::TIME_SCALE_RST;
	logic signed [18:0] vtx_wire_q [3] = '{default: '0};
	logic signed [18:0] vtx_time_q [3] = '{default: '0};

	htp_pkg::hit_word_t   hit_backlog [$];
	htp_pkg::polar_word_t pending_polar [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_tick = 0;
	int          stall_mode = 0;

	hit_to_polar_about_vertex #(.CORDIC_STAGES(CORDIC_N)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.hit_valid   (hit_valid),
		.hit_stall   (hit_stall),
		.hit_word    (hit_word),
		.polar_valid (polar_valid),
		.polar_stall (polar_stall),
		.polar_word  (polar_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scaled positions in 1/64 cm, rounded half up and saturated.
	function automatic longint wire_pos_of(input longint wire_num, input longint pitch);
		longint p;
		p = (wire_num * pitch + 512) >>> 10;
		return (p > longint'(htp_pkg::POS_MAX)) ? longint'(htp_pkg::POS_MAX) : p;
	endfunction

	function automatic longint time_pos_of(input longint ticks, input longint scale);
		longint p;
		p = (ticks * scale + 8192) >>> 14;
		return (p > longint'(htp_pkg::POS_MAX)) ? longint'(htp_pkg::POS_MAX) : p;
	endfunction

	// Integer square root, rounded half up.
	function automatic longint unsigned sqrt_round(input longint unsigned n);
		longint unsigned rem, root, step_bit;
		rem = n;
		root = 0;
		step_bit = 64'h1 << 62;
		while (step_bit > rem)
			step_bit >>= 2;
		while (step_bit != 0) begin
			if (rem >= root + step_bit) begin
				rem -= root + step_bit;
				root = (root >> 1) + step_bit;
			end else begin
				root >>= 1;
			end
			step_bit >>= 2;
		end
		if (n > root * root + root)
			root++;
		return root;
	endfunction

	// Vectoring CORDIC: accumulated angle of (dx, dt) in 2^-16 degree.
	function automatic longint cordic_angle_q16(input longint dx, input longint dt);
		longint x, y, z, t, xs, ys;
		x = dx * 1048576;
		y = dt * 1048576;
		z = 0;
		// Left half plane: rotate by a quarter turn first.
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * DEG_Q16;
			end else begin
				t = x; x = -y; y = t; z = -90 * DEG_Q16;
			end
		end
		for (int i = 0; i < CORDIC_N && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_Q16[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_Q16[i];
			end
		end
		return z;
	endfunction

	// Expected polar word of one hit under the current register copy.
	function automatic htp_pkg::polar_word_t polar_of_hit(input htp_pkg::hit_word_t h);
		htp_pkg::polar_word_t r;
		longint wpos, tpos, vw, vt, dx, dt, ang;
		longint unsigned rad;
		wpos = wire_pos_of(longint'(h.wire_req), longint'(pitch_q));
		tpos = time_pos_of(longint'(h.peak_time), longint'(scale_q));
		vw = 0;
		vt = 0;
		if (h.plane < 2'd3) begin
			vw = longint'(vtx_wire_q[h.plane]);
			vt = longint'(vtx_time_q[h.plane]);
		end
		dx = wpos - vw;
		dt = tpos - vt;
		rad = sqrt_round(longint'(dx * dx + dt * dt));
		if (rad > longint'(htp_pkg::RAD_MAX))
			rad = longint'(htp_pkg::RAD_MAX);
		// A hit at the vertex points back; one on the negative wire axis wraps to 0.
		if (dx == 0 && dt == 0) begin
			ang = longint'(htp_pkg::ANGLE_HALF);
		end else if (dt == 0 && dx < 0) begin
			ang = 0;
		end else begin
			ang = (cordic_angle_q16(dx, dt) + 180 * DEG_Q16 + 256) >>> 9;
			while (ang < 0)
				ang += longint'(htp_pkg::ANGLE_FULL);
			while (ang >= longint'(htp_pkg::ANGLE_FULL))
				ang -= longint'(htp_pkg::ANGLE_FULL);
		end
		r.radius = rad[18:0];
		r.angle = ang[15:0];
		r.wire_position = wpos[17:0];
		r.time_position = tpos[17:0];
		r.charge_out = h.charge;
		r.plane_out = h.plane;
		r.hit_index_out = h.hit_index;
		return r;
	endfunction

	function automatic htp_pkg::hit_word_t make_hit(input int plane, input int wire_num,
			input int ticks, input int charge, input int index);
		htp_pkg::hit_word_t h;
		h.plane = plane[1:0];
		h.wire_req = wire_num[12:0];
		h.peak_time = ticks[16:0];
		h.charge = charge[19:0];
		h.hit_index = index[19:0];
		return h;
	endfunction

	// Append one hit to the driver's backlog.
	task automatic add_hit(input htp_pkg::hit_word_t h);
		hit_backlog.insert(hit_backlog.size(), h);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// One register write; the local copy follows at once since the block is idle.
	task automatic write_reg(input logic [htp_pkg::CFG_IW-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[htp_pkg::CFG_DW-1:0];
		if (idx == htp_pkg::REG_WIRE_PITCH)
			pitch_q = value[15:0];
		else if (idx == htp_pkg::REG_TIME_SCALE)
			scale_q = value[15:0];
		else if (idx >= htp_pkg::REG_VTX_WIRE0 && idx <= htp_pkg::REG_VTX_WIRE2)
			vtx_wire_q[idx - htp_pkg::REG_VTX_WIRE0] = value[18:0];
		else
			vtx_time_q[idx - htp_pkg::REG_VTX_TIME0] = value[18:0];
	endtask

	task automatic apply_settings(input int pitch, input int scale, input int vw [3],
			input int vt [3]);
		write_reg(htp_pkg::REG_WIRE_PITCH, pitch);
		write_reg(htp_pkg::REG_TIME_SCALE, scale);
		write_reg(htp_pkg::REG_VTX_WIRE0, vw[0]);
		write_reg(htp_pkg::REG_VTX_WIRE1, vw[1]);
		write_reg(htp_pkg::REG_VTX_WIRE2, vw[2]);
		write_reg(htp_pkg::REG_VTX_TIME0, vt[0]);
		write_reg(htp_pkg::REG_VTX_TIME1, vt[1]);
		write_reg(htp_pkg::REG_VTX_TIME2, vt[2]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random scales; vertices mostly inside the reachable area so hits surround them.
	task automatic random_settings();
		int pitch, scale;
		int vw [3], vt [3];
		pitch = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 65535);
		scale = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 65535);
		for (int p = 0; p < 3; p++) begin
			if ($urandom_range(0, 3) == 0) begin
				vw[p] = int'($urandom_range(0, 524287)) - 262144;
				vt[p] = int'($urandom_range(0, 524287)) - 262144;
			end else begin
				vw[p] = int'(wire_pos_of($urandom_range(0, 8191), pitch));
				vt[p] = int'(time_pos_of($urandom_range(0, 131071), scale));
			end
		end
		apply_settings(pitch, scale, vw, vt);
	endtask

	task automatic push_random_hits(input int count);
		for (int n = 0; n < count; n++)
			add_hit(make_hit($urandom_range(0, 3), $urandom_range(0, 8191),
				$urandom_range(0, 131071), $urandom_range(0, 1048575),
				$urandom_range(0, 1048575)));
	endtask

	// Wait until every queued hit has gone in and every word has come out.
	task automatic wait_drain();
		do
			@(negedge clk);
		while (hit_backlog.size() != 0 || hit_valid || pending_polar.size() != 0);
	endtask

	// Sequence of register settings and hits.
	initial begin
		int vw [3], vt [3];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: vertex at the origin on every plane.
		add_hit(make_hit(0, 0, 0, 0, 0));
		add_hit(make_hit(0, 8191, 0, 1, 1));
		add_hit(make_hit(1, 0, 131071, 2, 2));
		add_hit(make_hit(2, 8191, 131071, 1048575, 1048575));
		add_hit(make_hit(3, 8191, 131071, 1048575, 1048575));
		add_hit(make_hit(3, 0, 0, 0, 0));
		add_hit(make_hit(1, 1, 1, 'hAAAAA, 'h55555));
		wait_drain();

		// Largest scales: saturation, the negative wire axis and exact vertex hits.
		vw = '{262143, -262144, int'(wire_pos_of(100, 65535))};
		vt = '{0, -262144, int'(time_pos_of(5000, 65535))};
		apply_settings(65535, 65535, vw, vt);
		add_hit(make_hit(0, 0, 0, 10, 20));
		add_hit(make_hit(0, 4095, 0, 11, 21));
		add_hit(make_hit(0, 8191, 0, 12, 22));
		add_hit(make_hit(0, 0, 1, 13, 23));
		add_hit(make_hit(1, 8191, 131071, 14, 24));
		add_hit(make_hit(2, 100, 5000, 15, 25));
		add_hit(make_hit(2, 101, 5000, 16, 26));
		add_hit(make_hit(2, 100, 4999, 17, 27));
		add_hit(make_hit(2, 100, 5001, 18, 28));
		add_hit(make_hit(3, 8191, 131071, 0, 1048575));
		wait_drain();

		// Zero scales: every position collapses to the origin.
		vw = '{-262144, 262143, 0};
		vt = '{262143, -262144, 0};
		apply_settings(0, 0, vw, vt);
		add_hit(make_hit(0, 8191, 131071, 30, 40));
		add_hit(make_hit(1, 8191, 131071, 31, 41));
		add_hit(make_hit(2, 8191, 131071, 32, 42));
		add_hit(make_hit(3, 1234, 4321, 33, 43));
		push_random_hits(100);
		wait_drain();

		// Random settings, each with a long random stream.
		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			push_random_hits(320);
			wait_drain();
		end

		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hit driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid <= 1'b0;
		end else begin
			if (hit_valid && !hit_stall)
				pending_polar.insert(pending_polar.size(), polar_of_hit(hit_word));
			if (hit_valid && hit_stall) begin
				// Hold the word until it is taken.
			end else if (gap_left > 0) begin
				gap_left--;
				hit_valid <= 1'b0;
			end else if (hit_backlog.size() != 0) begin
				hit_word <= hit_backlog.pop_front();
				hit_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				hit_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: one of five patterns, chosen anew at random as the run goes on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_stall <= 1'b0;
		end else begin
			stall_tick++;
			if (stall_tick % 97 == 0)
				stall_mode = $urandom_range(0, 4);
			case (stall_mode)
				0: begin
					polar_stall <= 1'b0;
				end
				1: begin
					polar_stall <= ($urandom_range(0, 1) == 1);
				end
				2: begin
					polar_stall <= (stall_tick % 3 == 0);
				end
				3: begin
					polar_stall <= ($urandom_range(0, 7) == 0);
				end
				default: begin
					polar_stall <= (stall_tick % 32 >= 24);
				end
			endcase
		end
	end

	// Output monitor: every accepted word against the oldest prediction.
	always @(posedge clk) begin
		htp_pkg::polar_word_t want;
		if (arst_n && polar_valid && !polar_stall) begin
			if (pending_polar.size() == 0) begin
				$error("polar word %p with no hit outstanding", polar_word);
				fail_count++;
			end else begin
				want = pending_polar.pop_front();
				check_field("radius", want.radius, polar_word.radius);
				check_field("angle", want.angle, polar_word.angle);
				check_field("wire_position", want.wire_position, polar_word.wire_position);
				check_field("time_position", want.time_position, polar_word.time_position);
				check_field("charge_out", want.charge_out, polar_word.charge_out);
				check_field("plane_out", want.plane_out, polar_word.plane_out);
				check_field("hit_index_out", want.hit_index_out, polar_word.hit_index_out);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
